[src/wft_pkg.sv]
package wft_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 24;
    localparam int IDX_W   = 8;
    localparam int CAP_W   = 9;

    localparam logic [CAP_W-1:0]   CAP_RESET = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    localparam logic [1:0] STAT_HIT  = 2'd0;
    localparam logic [1:0] STAT_NEW  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_LONG = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_META,
        ST_CHAR,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } buf_ctl_t;

    typedef struct packed {
        logic meta_wr;
        logic meta_rd;
        logic chr_wr;
        logic chr_rd;
    } tbl_ctl_t;

endpackage

[src/wft_word_buf.sv]
module wft_word_buf
    import wft_pkg::*;
#(
    parameter int MAX_WORD_LEN = 49
)
(
    input  logic                            clk,
    input  buf_ctl_t                        ctl,
    input  logic [$clog2(MAX_WORD_LEN)-1:0] wr_addr,
    input  logic [CHAR_W-1:0]               wr_data,
    input  logic [$clog2(MAX_WORD_LEN)-1:0] rd_addr,
    output logic [CHAR_W-1:0]               rd_data
);

    logic [CHAR_W-1:0] mem [MAX_WORD_LEN];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/wft_table.sv]
module wft_table
    import wft_pkg::*;
#(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_WORD_LEN = 49
)
(
    input  logic                               clk,
    input  tbl_ctl_t                           ctl,
    input  logic [$clog2(MAX_ENTRIES)-1:0]     slot,
    input  logic [$clog2(MAX_WORD_LEN)-1:0]    pos,
    input  logic [CHAR_W-1:0]                  chr_wr_data,
    output logic [CHAR_W-1:0]                  chr_rd_data,
    input  logic [$clog2(MAX_WORD_LEN+1)-1:0]  meta_wr_len,
    input  logic [COUNT_W-1:0]                 meta_wr_count,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0]  meta_rd_len,
    output logic [COUNT_W-1:0]                 meta_rd_count
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int KW = $clog2(MAX_WORD_LEN);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int MW = LW + COUNT_W;

    // each entry owns a power-of-two row of character slots
    logic [CHAR_W-1:0] chr_mem  [MAX_ENTRIES << KW];
    logic [MW-1:0]     meta_mem [MAX_ENTRIES];

    logic [CHAR_W-1:0] chr_rd_reg;
    logic [MW-1:0]     meta_rd_reg;
    logic [SW+KW-1:0]  chr_addr;

    assign chr_addr = {slot, pos};

    always_ff @(posedge clk)
    begin
        if (ctl.chr_wr)
        begin
            chr_mem[chr_addr] <= chr_wr_data;
        end
        if (ctl.chr_rd)
        begin
            chr_rd_reg <= chr_mem[chr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.meta_wr)
        begin
            meta_mem[slot] <= {meta_wr_len, meta_wr_count};
        end
        if (ctl.meta_rd)
        begin
            meta_rd_reg <= meta_mem[slot];
        end
    end

    assign chr_rd_data   = chr_rd_reg;
    assign meta_rd_len   = meta_rd_reg[MW-1:COUNT_W];
    assign meta_rd_count = meta_rd_reg[COUNT_W-1:0];

endmodule

[src/wft_ctrl.sv]
module wft_ctrl
    import wft_pkg::*;
#(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_WORD_LEN = 49
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [CHAR_W-1:0]                  char_code,
    input  logic                               last_char,
    output logic                               busy,
    input  logic [CAP_W-1:0]                   capacity,
    output buf_ctl_t                           buf_ctl,
    output logic [$clog2(MAX_WORD_LEN)-1:0]    buf_wr_addr,
    output logic [CHAR_W-1:0]                  buf_wr_data,
    output logic [$clog2(MAX_WORD_LEN)-1:0]    buf_rd_addr,
    input  logic [CHAR_W-1:0]                  buf_rd_data,
    output tbl_ctl_t                           tbl_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0]     tbl_slot,
    output logic [$clog2(MAX_WORD_LEN)-1:0]    tbl_pos,
    output logic [CHAR_W-1:0]                  chr_wr_data,
    input  logic [CHAR_W-1:0]                  chr_rd_data,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0]  meta_wr_len,
    output logic [COUNT_W-1:0]                 meta_wr_count,
    input  logic [$clog2(MAX_WORD_LEN+1)-1:0]  meta_rd_len,
    input  logic [COUNT_W-1:0]                 meta_rd_count,
    output logic                               done,
    output logic [IDX_W-1:0]                   entry_index,
    output logic [COUNT_W-1:0]                 word_count,
    output logic [1:0]                         status
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int UW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = $clog2(MAX_WORD_LEN);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int CW = (UW > CAP_W) ? UW : CAP_W;

    state_t state_reg, state_next;

    logic [LW-1:0]      wl_reg, wl_next;
    logic               over_reg, over_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [KW-1:0]      k_reg, k_next;
    logic               done_reg, done_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]         stat_reg, stat_next;

    logic               accept;
    logic               room;
    logic               long_word;
    logic               used_zero;
    logic               can_insert;
    logic               slot_more;
    logic               len_eq;
    logic               chr_eq;
    logic               k_last;
    logic               go_miss;
    logic [COUNT_W-1:0] cnt_sat;
    logic [SW+IDX_W-1:0] slot_ext;
    logic [SW-1:0]      slot_inc;
    logic [KW-1:0]      k_inc;

    assign accept     = start && (state_reg == ST_IDLE);
    assign room       = wl_reg < LW'(MAX_WORD_LEN);
    assign long_word  = over_reg || !room;
    assign used_zero  = used_reg == '0;
    assign can_insert = (CW'(used_reg) < CW'(capacity)) && (used_reg < UW'(MAX_ENTRIES));
    assign slot_more  = (UW'(slot_reg) + UW'(1)) < used_reg;
    assign len_eq     = meta_rd_len == wl_reg;
    assign chr_eq     = chr_rd_data == buf_rd_data;
    assign k_last     = (LW'(k_reg) + LW'(1)) == wl_reg;
    assign cnt_sat    = (meta_rd_count == COUNT_MAX) ? meta_rd_count
                                                     : meta_rd_count + COUNT_W'(1);
    assign slot_ext   = {{IDX_W{1'b0}}, slot_reg};
    assign slot_inc   = slot_reg + SW'(1);
    assign k_inc      = k_reg + KW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_char && !long_word)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!used_zero)
                begin
                    state_next = ST_META;
                end
                else
                begin
                    state_next = can_insert ? ST_COPY : ST_IDLE;
                end
            end
            ST_META:
            begin
                if (len_eq)
                begin
                    state_next = ST_CHAR;
                end
                else if (!slot_more)
                begin
                    state_next = can_insert ? ST_COPY : ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (chr_eq)
                begin
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (slot_more)
                begin
                    state_next = ST_META;
                end
                else
                begin
                    state_next = can_insert ? ST_COPY : ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (k_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wl_next       = wl_reg;
        over_next     = over_reg;
        used_next     = used_reg;
        slot_next     = slot_reg;
        k_next        = k_reg;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        stat_next     = stat_reg;
        go_miss       = 1'b0;
        buf_ctl       = '0;
        tbl_ctl       = '0;
        buf_wr_addr   = wl_reg[KW-1:0];
        buf_wr_data   = char_code;
        buf_rd_addr   = k_reg;
        tbl_slot      = slot_reg;
        tbl_pos       = k_reg;
        chr_wr_data   = buf_rd_data;
        meta_wr_len   = wl_reg;
        meta_wr_count = cnt_sat;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    buf_ctl.wr = room;
                    over_next  = over_reg || !room;
                    if (room)
                    begin
                        wl_next = wl_reg + LW'(1);
                    end
                    if (last_char)
                    begin
                        slot_next = '0;
                        k_next    = '0;
                        if (long_word)
                        begin
                            done_next = 1'b1;
                            idx_next  = '0;
                            cnt_next  = '0;
                            stat_next = STAT_LONG;
                            wl_next   = '0;
                            over_next = 1'b0;
                        end
                    end
                end
            end
            ST_START:
            begin
                if (!used_zero)
                begin
                    tbl_ctl.meta_rd = 1'b1;
                end
                else
                begin
                    go_miss = 1'b1;
                end
            end
            ST_META:
            begin
                if (len_eq)
                begin
                    tbl_ctl.chr_rd = 1'b1;
                    buf_ctl.rd     = 1'b1;
                    tbl_pos        = '0;
                    buf_rd_addr    = '0;
                    k_next         = '0;
                end
                else if (slot_more)
                begin
                    tbl_ctl.meta_rd = 1'b1;
                    tbl_slot        = slot_inc;
                    slot_next       = slot_inc;
                end
                else
                begin
                    go_miss = 1'b1;
                end
            end
            ST_CHAR:
            begin
                if (chr_eq)
                begin
                    if (k_last)
                    begin
                        tbl_ctl.meta_wr = 1'b1;
                        done_next       = 1'b1;
                        idx_next        = slot_ext[IDX_W-1:0];
                        cnt_next        = cnt_sat;
                        stat_next       = STAT_HIT;
                        wl_next         = '0;
                    end
                    else
                    begin
                        tbl_ctl.chr_rd = 1'b1;
                        buf_ctl.rd     = 1'b1;
                        tbl_pos        = k_inc;
                        buf_rd_addr    = k_inc;
                        k_next         = k_inc;
                    end
                end
                else if (slot_more)
                begin
                    tbl_ctl.meta_rd = 1'b1;
                    tbl_slot        = slot_inc;
                    slot_next       = slot_inc;
                end
                else
                begin
                    go_miss = 1'b1;
                end
            end
            ST_COPY:
            begin
                // buffer byte k arrived this cycle, byte k+1 is fetched alongside
                tbl_ctl.chr_wr = 1'b1;
                if (k_last)
                begin
                    tbl_ctl.meta_wr = 1'b1;
                    meta_wr_count   = COUNT_W'(1);
                    used_next       = used_reg + UW'(1);
                    done_next       = 1'b1;
                    idx_next        = slot_ext[IDX_W-1:0];
                    cnt_next        = COUNT_W'(1);
                    stat_next       = STAT_NEW;
                    wl_next         = '0;
                end
                else
                begin
                    buf_ctl.rd  = 1'b1;
                    buf_rd_addr = k_inc;
                    k_next      = k_inc;
                end
            end
            default:
            begin
                wl_next = '0;
            end
        endcase

        // no entry matched: append when there is room, else drop
        if (go_miss)
        begin
            if (can_insert)
            begin
                buf_ctl.rd  = 1'b1;
                buf_rd_addr = '0;
                k_next      = '0;
                slot_next   = used_reg[SW-1:0];
            end
            else
            begin
                done_next = 1'b1;
                idx_next  = '0;
                cnt_next  = '0;
                stat_next = STAT_FULL;
                wl_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wl_reg    <= '0;
            over_reg  <= 1'b0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wl_reg    <= wl_next;
            over_reg  <= over_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        k_reg    <= k_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        stat_reg <= stat_next;
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign entry_index = idx_reg;
    assign word_count  = cnt_reg;
    assign status      = stat_reg;

endmodule

[src/word_frequency_table.sv]
// channel   direction  handshake                        payload
// request   in         start high, busy low             char_code, last_char
// result    out        done strobe, one cycle           entry_index, word_count, status
// config    in         cfg_valid and cfg_ready high     cfg_data (capacity)
//
// a character that does not end a word, or ends an over-long one, is taken in the idle state.
// any other final character goes through a start step, a metadata read per entry searched,
// a byte-by-byte compare on entries of equal length, and a copy of the word when appended;
// the single address port of the character store serialises this; busy is high meanwhile.
// reset clears the table to empty at once; no clearing pass is needed.
// results cannot be stalled: done is high for exactly one cycle per word.
module word_frequency_table
    import wft_pkg::*;
#(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_WORD_LEN = 49
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               last_char,
    output logic               done,
    output logic [IDX_W-1:0]   entry_index,
    output logic [COUNT_W-1:0] word_count,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int KW = $clog2(MAX_WORD_LEN);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);

    logic [CAP_W-1:0]   capacity_reg, capacity_next;

    buf_ctl_t           buf_ctl;
    logic [KW-1:0]      buf_wr_addr;
    logic [CHAR_W-1:0]  buf_wr_data;
    logic [KW-1:0]      buf_rd_addr;
    logic [CHAR_W-1:0]  buf_rd_data;

    tbl_ctl_t           tbl_ctl;
    logic [SW-1:0]      tbl_slot;
    logic [KW-1:0]      tbl_pos;
    logic [CHAR_W-1:0]  chr_wr_data;
    logic [CHAR_W-1:0]  chr_rd_data;
    logic [LW-1:0]      meta_wr_len;
    logic [COUNT_W-1:0] meta_wr_count;
    logic [LW-1:0]      meta_rd_len;
    logic [COUNT_W-1:0] meta_rd_count;

    assign cfg_ready     = 1'b1;
    assign capacity_next = (cfg_valid && cfg_ready) ? cfg_data : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    wft_ctrl #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .char_code     (char_code),
        .last_char     (last_char),
        .busy          (busy),
        .capacity      (capacity_reg),
        .buf_ctl       (buf_ctl),
        .buf_wr_addr   (buf_wr_addr),
        .buf_wr_data   (buf_wr_data),
        .buf_rd_addr   (buf_rd_addr),
        .buf_rd_data   (buf_rd_data),
        .tbl_ctl       (tbl_ctl),
        .tbl_slot      (tbl_slot),
        .tbl_pos       (tbl_pos),
        .chr_wr_data   (chr_wr_data),
        .chr_rd_data   (chr_rd_data),
        .meta_wr_len   (meta_wr_len),
        .meta_wr_count (meta_wr_count),
        .meta_rd_len   (meta_rd_len),
        .meta_rd_count (meta_rd_count),
        .done          (done),
        .entry_index   (entry_index),
        .word_count    (word_count),
        .status        (status)
    );

    wft_word_buf #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_word_buf (
        .clk     (clk),
        .ctl     (buf_ctl),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    wft_table #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_table (
        .clk           (clk),
        .ctl           (tbl_ctl),
        .slot          (tbl_slot),
        .pos           (tbl_pos),
        .chr_wr_data   (chr_wr_data),
        .chr_rd_data   (chr_rd_data),
        .meta_wr_len   (meta_wr_len),
        .meta_wr_count (meta_wr_count),
        .meta_rd_len   (meta_rd_len),
        .meta_rd_count (meta_rd_count)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import wft_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int WORD_MAX    = 49;
    localparam int SETTLE      = 8;
    localparam int QUIET_LIMIT = 100000;
    localparam int PHASE_CHARS = 110;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [COUNT_W-1:0] cnt;
        logic [1:0]         st;
    } word_result_t;

    // tracks the word table and holds the results still owed by the block
    class word_tally;
        bit [CHAR_W-1:0]  entry_chars [TABLE_DEPTH][WORD_MAX];
        int unsigned      entry_len [TABLE_DEPTH];
        bit [COUNT_W-1:0] entry_cnt [TABLE_DEPTH];
        int unsigned      entries_used;
        bit [CHAR_W-1:0]  word_buf [WORD_MAX];
        int unsigned      word_len;
        bit               too_long;
        bit [CAP_W-1:0]   capacity;
        word_result_t     pending [$];
        int unsigned      mismatches;

        function new();
            capacity     = CAP_RESET;
            entries_used = 0;
            word_len     = 0;
            too_long     = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_capacity(bit [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function void take_char(bit [CHAR_W-1:0] ch, bit last);
            int unsigned  limit;
            int           slot;
            bit           same;
            word_result_t r;
            if (word_len < WORD_MAX)
            begin
                word_buf[word_len] = ch;
                word_len++;
            end
            else
                too_long = 1'b1;
            if (!last)
                return;
            limit = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
            slot  = -1;
            r.idx = '0;
            r.cnt = '0;
            if (too_long)
                r.st = STAT_LONG;
            else
            begin
                // linear search in insertion order, first hit wins
                for (int e = 0; e < entries_used && slot < 0; e++)
                begin
                    same = (entry_len[e] == word_len);
                    for (int k = 0; k < word_len && same; k++)
                        if (entry_chars[e][k] != word_buf[k])
                            same = 1'b0;
                    if (same)
                        slot = e;
                end
                if (slot >= 0)
                begin
                    if (entry_cnt[slot] != COUNT_MAX)
                        entry_cnt[slot]++;
                    r.idx = slot[IDX_W-1:0];
                    r.cnt = entry_cnt[slot];
                    r.st  = STAT_HIT;
                end
                else if (entries_used < limit)
                begin
                    for (int k = 0; k < word_len; k++)
                        entry_chars[entries_used][k] = word_buf[k];
                    entry_len[entries_used] = word_len;
                    entry_cnt[entries_used] = COUNT_W'(1);
                    r.idx = entries_used[IDX_W-1:0];
                    r.cnt = COUNT_W'(1);
                    r.st  = STAT_NEW;
                    entries_used++;
                end
                else
                    r.st = STAT_FULL;
            end
            pending.push_back(r);
            word_len = 0;
            too_long = 1'b0;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", what);
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [COUNT_W-1:0] cnt,
                                   logic [1:0] st);
            word_result_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("unexpected result: idx %0d count %0d status %0d",
                               idx, cnt, st));
                return;
            end
            want = pending.pop_front();
            if (want.idx !== idx || want.cnt !== cnt || want.st !== st)
                flag($sformatf({"result mismatch: expected idx %0d count %0d status %0d,",
                                " got idx %0d count %0d status %0d"},
                               want.idx, want.cnt, want.st, idx, cnt, st));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CHAR_W-1:0]  char_code;
    logic               last_char;
    logic               done;
    logic [IDX_W-1:0]   entry_index;
    logic [COUNT_W-1:0] word_count;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;

    word_tally       tally = new();
    int              sender_idle_pct;
    int              chars_sent;
    int              quiet_cycles;
    bit [CHAR_W-1:0] long_pool [3][WORD_MAX];

    word_frequency_table #(
        .MAX_ENTRIES  (TABLE_DEPTH),
        .MAX_WORD_LEN (WORD_MAX)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .char_code   (char_code),
        .last_char   (last_char),
        .done        (done),
        .entry_index (entry_index),
        .word_count  (word_count),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a result always belongs to an earlier word than a request on the same edge
            if (done)
                tally.check_result(entry_index, word_count, status);
            if (start && !busy)
                tally.take_char(char_code, last_char);
            if (cfg_valid && cfg_ready)
                tally.set_capacity(cfg_data);
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_char(input bit [CHAR_W-1:0] ch, input bit last);
        // each sender cycle idles with the phase's probability
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        char_code <= ch;
        last_char <= last;
        do
            @(posedge clk);
        while (busy);
        chars_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (tally.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input bit [CAP_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input bit [CAP_W-1:0] cap, input int idle_pct);
        int              pick;
        int              len;
        int              p;
        int              first_char;
        bit [CHAR_W-1:0] ch;
        write_capacity(cap);
        sender_idle_pct = idle_pct;
        first_char      = chars_sent;
        while (chars_sent - first_char < PHASE_CHARS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // short words from a tiny alphabet so repeats are common
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    send_char(CHAR_W'($urandom_range(97, 99)), k == len - 1);
            end
            else if (pick < 88)
            begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_char(CHAR_W'($urandom_range(255)), k == len - 1);
            end
            else
            begin
                // long words built on a few fixed prefixes, some running past the limit
                p = $urandom_range(2);
                if (pick < 91)
                    len = WORD_MAX;
                else if (pick < 94)
                    len = WORD_MAX - 1;
                else
                    len = $urandom_range(WORD_MAX + 1, WORD_MAX + 6);
                for (int k = 0; k < len; k++)
                begin
                    ch = (k < WORD_MAX) ? long_pool[p][k] : CHAR_W'($urandom_range(255));
                    send_char(ch, k == len - 1);
                end
            end
            if ($urandom_range(99) < 4)
                drain_results();
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        char_code       = '0;
        last_char       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        sender_idle_pct = 31;
        chars_sent      = 0;
        quiet_cycles    = 0;
        for (int p = 0; p < 3; p++)
            for (int k = 0; k < WORD_MAX; k++)
                long_pool[p][k] = CHAR_W'($urandom_range(255));
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // no room at all: drops, with an over-long word still reported as too long
        write_capacity(9'd0);
        send_char(8'h01, 1'b1);
        for (int k = 0; k <= WORD_MAX; k++)
            send_char((k == 0) ? 8'hFF : CHAR_W'(k), k == WORD_MAX);
        send_char(8'h00, 1'b1);

        // single slot: insert, refuse a second word, count a repeat
        write_capacity(9'd1);
        send_char(8'h01, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(8'h01, 1'b1);

        // out of range capacity saturates to the full table
        write_capacity(9'd511);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b1);
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b1);

        run_phase(9'd24, 31);
        // capacity below the entries in use: lookups only
        run_phase(9'd3, 46);
        run_phase(9'd256, 0);

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (tally.mismatches == 0 && tally.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
src/wft_pkg.sv
src/wft_word_buf.sv
src/wft_table.sv
src/wft_ctrl.sv
src/word_frequency_table.sv
tb/testbench.sv
